FILE: src/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared constants, codes and control types of the ring queue with search.
// ----------------------------------------------------------------------------
package rqs_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int MATCH_W = 5;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic signed [MATCH_W-1:0] MATCH_NONE = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_FIND = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ_WAIT,
		S_SCAN
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    accept;      // capture the input transfer
		logic    do_enq;      // write at tail, advance tail
		logic    do_deq;      // read at head, advance head
		logic    find_start;  // read at head, clear scan state
		logic    scan_next;   // fold one compare, read next slot
		logic    res_load;    // load result registers
		logic    res_pop;     // result carries the read data
		logic    res_match;   // result carries the match position
		status_t res_status;
	} rqs_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    scan_last;
	} rqs_stat_t;

	// Next slot in the ring
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
		logic [IDX_W-1:0] n;
		if (s == IDX_LAST) begin
			n = '0;
		end else begin
			n = s + IDX_W'(1);
		end
		return n;
	endfunction

endpackage

FILE: src/rqs_ram.sv
// ----------------------------------------------------------------------------
// rqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/rqs_ctrl.sv
// ----------------------------------------------------------------------------
// rqs_ctrl
// Operation sequencer: decodes the captured opcode and steps the scan.
// ----------------------------------------------------------------------------
module rqs_ctrl import rqs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  rqs_stat_t stat,
	output rqs_cmd_t  cmd,
	output logic      busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (stat.op == OP_DEQ && !stat.empty) begin
					state_d = S_DEQ_WAIT;
				end else if (stat.op == OP_FIND && !stat.empty) begin
					state_d = S_SCAN;
				end
			end
			S_DEQ_WAIT: begin
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		cmd.res_status = STAT_OK;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.accept = start;
			end
			S_EXEC: begin
				case (stat.op)
					OP_ENQ: begin
						cmd.res_load = 1'b1;
						if (stat.full) begin
							cmd.res_status = STAT_FULL;
						end else begin
							cmd.do_enq = 1'b1;
						end
					end
					OP_DEQ: begin
						if (stat.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.do_deq = 1'b1;
						end
					end
					OP_FIND: begin
						if (stat.empty) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STAT_EMPTY;
						end else begin
							cmd.find_start = 1'b1;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
					end
				endcase
			end
			S_DEQ_WAIT: begin
				cmd.res_load = 1'b1;
				cmd.res_pop  = 1'b1;
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					cmd.res_load  = 1'b1;
					cmd.res_match = 1'b1;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: src/rqs_dp.sv
// ----------------------------------------------------------------------------
// rqs_dp
// Queue datapath: ring pointers, occupancy, entry RAM, scan compare and
// result registers.
// ----------------------------------------------------------------------------
module rqs_dp import rqs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [OP_W-1:0]           opcode,
	input  logic signed [DATA_W-1:0]  push_value,
	input  logic signed [DATA_W-1:0]  search_key,
	input  rqs_cmd_t                  cmd,
	output rqs_stat_t                 stat,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic signed [DATA_W-1:0]  popped_value,
	output logic signed [MATCH_W-1:0] match_position
);

	opcode_t                     op_q;
	logic [DATA_W-1:0]           push_q;
	logic [DATA_W-1:0]           key_q;
	logic [IDX_W-1:0]            head_q;
	logic [IDX_W-1:0]            tail_q;
	logic [CNT_W-1:0]            occ_q;
	logic [IDX_W-1:0]            scan_slot_q;
	logic [IDX_W-1:0]            cmp_q;
	logic signed [MATCH_W-1:0]   match_acc_q;
	logic signed [MATCH_W-1:0]   match_next;
	logic [IDX_W-1:0]            raddr;
	logic [DATA_W-1:0]           rdata;
	logic                        hit;
	logic                        done_q;
	status_t                     status_q;
	logic [DATA_W-1:0]           popped_q;
	logic signed [MATCH_W-1:0]   match_q;

	rqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.do_enq),
		.waddr (tail_q),
		.wdata (push_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The scan reads one slot ahead of the compare
	assign raddr      = (cmd.do_deq || cmd.find_start) ? head_q : scan_slot_q;
	assign hit        = (rdata == key_q);
	assign match_next = hit ? MATCH_W'(cmp_q) : match_acc_q;

	assign stat.op        = op_q;
	assign stat.full      = (occ_q == CNT_FULL);
	assign stat.empty     = (occ_q == '0);
	assign stat.scan_last = ((CNT_W'(cmp_q) + CNT_W'(1)) == occ_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode_t'(opcode);
			push_q <= push_value;
			key_q  <= search_key;
		end
		if (cmd.find_start) begin
			scan_slot_q <= next_slot(head_q);
			cmp_q       <= '0;
			match_acc_q <= MATCH_NONE;
		end else if (cmd.scan_next) begin
			scan_slot_q <= next_slot(scan_slot_q);
			cmp_q       <= cmp_q + IDX_W'(1);
			match_acc_q <= match_next;
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			popped_q <= cmd.res_pop ? rdata : '0;
			match_q  <= cmd.res_match ? match_next : MATCH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
			if (cmd.do_enq) begin
				tail_q <= next_slot(tail_q);
				occ_q  <= occ_q + CNT_W'(1);
			end
			if (cmd.do_deq) begin
				head_q <= next_slot(head_q);
				occ_q  <= occ_q - CNT_W'(1);
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign popped_value   = popped_q;
	assign match_position = match_q;

endmodule

FILE: src/ring_queue_with_search_core.sv
// Results: the start transfer moves the controller to its execute state, and
// the done register strobes from there; dequeue adds the registered RAM read,
// find one scan state per stored entry. A new start is taken only while idle;
// the find scan reads one entry per cycle through the RAM's single read port.
// Reset clears pointers, occupancy and control at once; entry RAM is not cleared.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// ring_queue_with_search_core
// Circular queue of signed words with enqueue, dequeue and last-match find.
// ----------------------------------------------------------------------------
module ring_queue_with_search_core import rqs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [OP_W-1:0]           opcode,
	input  logic signed [DATA_W-1:0]  push_value,
	input  logic signed [DATA_W-1:0]  search_key,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic signed [DATA_W-1:0]  popped_value,
	output logic signed [MATCH_W-1:0] match_position
);

	rqs_cmd_t  cmd;
	rqs_stat_t stat;

	rqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rqs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.push_value     (push_value),
		.search_key     (search_key),
		.cmd            (cmd),
		.stat           (stat),
		.done           (done),
		.status         (status),
		.popped_value   (popped_value),
		.match_position (match_position)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without work in progress");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (popped_value == '0 && match_position == MATCH_NONE))
		else $error("full status with non-default result fields");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (popped_value == '0 && match_position == MATCH_NONE))
		else $error("empty status with non-default result fields");
`endif

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks ring_queue_with_search_core against a behavioral queue kept in step
// with every start transfer. A short directed table covers the empty and full
// cases, the word extremes, zero as a stored value and the no-op code. The
// random part that follows uses fill, drain and balanced operation mixes, and
// search keys that are mostly taken from the live queue contents.
// ----------------------------------------------------------------------------
module testbench import rqs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		status_t                   stat;
		word_t                     popped;
		logic signed [MATCH_W-1:0] pos;
	} queue_result_t;

	typedef struct packed {
		opcode_t       op;
		word_t         pushv;
		word_t         key;
		logic [7:0]    reps;
		logic          typed;
		queue_result_t res;
	} stim_row_t;

	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	localparam queue_result_t RES_OK    = '{STAT_OK, '0, MATCH_NONE};
	localparam queue_result_t RES_FULL  = '{STAT_FULL, '0, MATCH_NONE};
	localparam queue_result_t RES_EMPTY = '{STAT_EMPTY, '0, MATCH_NONE};
	localparam queue_result_t RES_HEAD  = '{STAT_OK, '0, '0};

	localparam int NUM_ROWS        = 23;
	localparam int ITEMS_PER_PHASE = 525;
	localparam int MIX_SPAN        = 40;
	localparam int STALL_LIMIT     = 1000;
	localparam int DRAIN_CYCLES    = 24;
	localparam int MAX_REPORTS     = 10;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	logic  [OP_W-1:0] opcode;
	word_t push_value;
	word_t search_key;
	logic  done;
	logic  [STAT_W-1:0] status;
	word_t popped_value;
	logic  signed [MATCH_W-1:0] match_position;

	// behavioral queue
	word_t ring_mem [DEPTH];
	int    ring_head;
	int    ring_tail;
	int    ring_fill;

	queue_result_t pending_results [$];
	stim_row_t     directed_rows [NUM_ROWS];
	int            idle_pct;
	int            err_count;
	int            stall_cycles;

	ring_queue_with_search_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.push_value     (push_value),
		.search_key     (search_key),
		.done           (done),
		.status         (status),
		.popped_value   (popped_value),
		.match_position (match_position)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic queue_result_t apply_queue_op(input opcode_t op, input word_t pushv,
			input word_t key);
		queue_result_t res;
		res = RES_OK;
		case (op)
			OP_ENQ: begin
				if (ring_fill == DEPTH) begin
					res.stat = STAT_FULL;
				end else begin
					ring_mem[ring_tail] = pushv;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_fill++;
				end
			end
			OP_DEQ: begin
				if (ring_fill == 0) begin
					res.stat = STAT_EMPTY;
				end else begin
					res.popped = ring_mem[ring_head];
					ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end
			end
			OP_FIND: begin
				if (ring_fill == 0) begin
					res.stat = STAT_EMPTY;
				end else begin
					// keep the last hit walking from head to tail
					for (int i = 0; i < ring_fill; i++) begin
						if (ring_mem[(ring_head + i) % DEPTH] == key) begin
							res.pos = MATCH_W'(i);
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(9))
			0, 1, 2, 3: w = word_t'($urandom_range(7)) - word_t'(3);
			4: w = WORD_MIN;
			5: w = WORD_MAX;
			6: w = '1;
			default: w = word_t'($urandom);
		endcase
		return w;
	endfunction

	function automatic opcode_t pick_op(input mix_t mix);
		int r;
		int enq_pct;
		int deq_pct;
		opcode_t op;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL: begin
				enq_pct = 60;
				deq_pct = 15;
			end
			MIX_DRAIN: begin
				enq_pct = 15;
				deq_pct = 60;
			end
			default: begin
				enq_pct = 38;
				deq_pct = 34;
			end
		endcase
		if (r < enq_pct) begin
			op = OP_ENQ;
		end else if (r < enq_pct + deq_pct) begin
			op = OP_DEQ;
		end else if (r < 96) begin
			op = OP_FIND;
		end else begin
			op = OP_NOP;
		end
		return op;
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Enter and leave at a falling edge. Start stays high when no gap follows.
	task automatic send_item(input opcode_t op, input word_t pushv, input word_t key,
			input logic typed, input queue_result_t typed_res);
		queue_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start      <= 1'b0;
			opcode     <= OP_W'($urandom_range(3));
			push_value <= word_t'($urandom);
			search_key <= word_t'($urandom);
			@(negedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		push_value <= pushv;
		search_key <= key;
		do begin
			@(posedge clk);
		end while (busy);
		predicted = apply_queue_op(op, pushv, key);
		pending_results.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// results cannot be held off: check every strobe
	always @(posedge clk) begin
		queue_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result: status %0d popped %0d pos %0d",
					status, popped_value, match_position));
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.stat || popped_value !== exp_res.popped ||
						match_position !== exp_res.pos) begin
					flag_error($sformatf({"mismatch: expected status %0d popped %0d pos %0d,",
						" got status %0d popped %0d pos %0d"},
						exp_res.stat, exp_res.popped, exp_res.pos,
						status, popped_value, match_position));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		mix_t    mix;
		opcode_t op;
		word_t   pushv;
		word_t   key;
		int      phase_idle [3];

		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = OP_NOP;
		push_value   = '0;
		search_key   = '0;
		ring_head    = 0;
		ring_tail    = 0;
		ring_fill    = 0;
		idle_pct     = 0;
		mix          = MIX_EVEN;
		phase_idle   = '{17, 66, 0};
		foreach (ring_mem[i]) begin
			ring_mem[i] = '0;
		end

		directed_rows = '{
			'{OP_DEQ,  '0,       '0,       8'd1,  1'b1, RES_EMPTY},
			'{OP_FIND, '0,       '0,       8'd1,  1'b1, RES_EMPTY},
			'{OP_NOP,  WORD_MAX, WORD_MIN, 8'd1,  1'b1, RES_OK},
			'{OP_ENQ,  '0,       WORD_MAX, 8'd1,  1'b1, RES_OK},
			'{OP_FIND, WORD_MIN, '0,       8'd1,  1'b1, RES_HEAD},
			'{OP_ENQ,  WORD_MIN, '0,       8'd1,  1'b1, RES_OK},
			'{OP_ENQ,  WORD_MAX, '1,       8'd1,  1'b1, RES_OK},
			'{OP_ENQ,  '1,       '0,       8'd1,  1'b1, RES_OK},
			'{OP_ENQ,  '0,       '1,       8'd1,  1'b1, RES_OK},
			'{OP_FIND, '1,       '0,       8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       WORD_MIN, 8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       WORD_MAX, 8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       32'sd5,   8'd1,  1'b0, RES_OK},
			'{OP_DEQ,  WORD_MAX, WORD_MAX, 8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       '0,       8'd1,  1'b0, RES_OK},
			'{OP_ENQ,  32'sd100, '0,       8'd12, 1'b0, RES_OK},
			'{OP_ENQ,  32'sd7,   '0,       8'd1,  1'b1, RES_FULL},
			'{OP_FIND, '0,       32'sd111, 8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       '1,       8'd1,  1'b0, RES_OK},
			'{OP_DEQ,  '1,       '1,       8'd1,  1'b0, RES_OK},
			'{OP_ENQ,  32'sd3,   '0,       8'd1,  1'b0, RES_OK},
			'{OP_FIND, '0,       32'sd3,   8'd1,  1'b0, RES_OK},
			'{OP_NOP,  '1,       '1,       8'd1,  1'b1, RES_OK}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++) begin
				send_item(directed_rows[r].op, directed_rows[r].pushv + word_t'(k),
					directed_rows[r].key, directed_rows[r].typed, directed_rows[r].res);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_idle[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % MIX_SPAN == 0) begin
					mix = mix_t'($urandom_range(2));
				end
				op    = pick_op(mix);
				pushv = pick_word();
				// search mostly for words that are stored right now
				if (ring_fill > 0 && $urandom_range(2) != 0) begin
					key = ring_mem[(ring_head + $urandom_range(ring_fill - 1)) % DEPTH];
				end else begin
					key = pick_word();
				end
				send_item(op, pushv, key, 1'b0, RES_OK);
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
